/* rtl/core/aesctr_pkg.sv */
package aesctr_pkg;

    localparam int BLOCKS_PER_REQUEST_DEF = 8;
    localparam int NUM_ROUNDS = 14;
    localparam int NUM_KEY_REGS = 4;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        KEY_WORD_0 = 2'd0,
        KEY_WORD_1 = 2'd1,
        KEY_WORD_2 = 2'd2,
        KEY_WORD_3 = 2'd3
    } t_key_reg;

    typedef struct packed {
        logic [63:0] counter_start;
        logic [63:0] nonce;
    } t_in_word;

    typedef struct packed {
        logic        last_block;
        logic [63:0] stream_high;
        logic [63:0] stream_low;
        logic [2:0]  block_index;
    } t_out_word;

    // tag that travels with a block through the round chain
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [2:0] index;
    } t_tag;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    function automatic logic [7:0] sb(input logic [7:0] x);
        return SBOX[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    // SubBytes + MixColumns for one byte, rotated right by 8*k
    function automatic logic [31:0] tcol(input logic [7:0] x, input logic [1:0] k);
        logic [7:0]  s;
        logic [7:0]  s2;
        logic [31:0] y;
        s  = sb(x);
        s2 = xtime(s);
        y  = {s2, s ^ s2, s, s};
        case (k)
            2'd0:    tcol = y;
            2'd1:    tcol = {y[7:0], y[31:8]};
            2'd2:    tcol = {y[15:0], y[31:16]};
            default: tcol = {y[23:0], y[31:24]};
        endcase
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] st,
                                               input logic [127:0] rk,
                                               input logic         fin);
        logic [31:0] w  [4];
        logic [31:0] n  [4];
        for (int j = 0; j < 4; j++) w[j] = st[32*j +: 32];
        for (int j = 0; j < 4; j++) begin
            if (fin) begin
                n[j] = {sb(w[(j+3)%4][31:24]), sb(w[(j+2)%4][23:16]),
                        sb(w[(j+1)%4][15:8]), sb(w[j][7:0])};
            end else begin
                n[j] = tcol(w[(j+3)%4][31:24], 2'd0) ^ tcol(w[(j+2)%4][23:16], 2'd1)
                     ^ tcol(w[(j+1)%4][15:8], 2'd2) ^ tcol(w[j][7:0], 2'd3);
            end
        end
        return {n[3], n[2], n[1], n[0]} ^ rk;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sb(w[31:24]), sb(w[23:16]), sb(w[15:8]), sb(w[7:0])};
    endfunction

    function automatic logic [31:0] rot_sub_word(input logic [31:0] w);
        return {sb(w[7:0]), sb(w[31:24]), sb(w[23:16]), sb(w[15:8])};
    endfunction

    function automatic logic [127:0] chain4(input logic [127:0] x, input logic [31:0] t);
        logic [31:0] a, b, c, d;
        a = x[31:0] ^ t;
        b = x[63:32] ^ a;
        c = x[95:64] ^ b;
        d = x[127:96] ^ c;
        return {d, c, b, a};
    endfunction

endpackage

/* rtl/core/aesctr_round_cell.sv */
// one round of the chain: state and both key halves advance together
module aesctr_round_cell #(
    parameter int RNUM = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  aesctr_pkg::t_tag     i_tag,
    input  logic [127:0]         i_st,
    input  logic [127:0]         i_kx,
    input  logic [127:0]         i_kz,
    output aesctr_pkg::t_tag     o_tag,
    output logic [127:0]         o_st,
    output logic [127:0]         o_kx,
    output logic [127:0]         o_kz
);
    import aesctr_pkg::*;

    localparam bit ODD_R = (RNUM % 2) == 1;
    localparam bit FIN   = RNUM == NUM_ROUNDS;
    localparam logic [7:0] RCON = 8'(1 << ((RNUM - 2) / 2));

    t_tag         r_tag;
    logic [127:0] r_st, r_kx, r_kz;
    logic [127:0] n_st, n_kx, n_kz;

    // odd rounds use z as is (the first) or expanded below; even rounds expand x and pass z through
    always_comb begin
        n_kx = i_kx;
        n_kz = i_kz;
        if (ODD_R) begin
            n_st = enc_round(i_st, i_kz, 1'b0);
        end else begin
            n_kx = chain4(i_kx, rot_sub_word(i_kz[127:96]) ^ {24'd0, RCON});
            n_st = enc_round(i_st, n_kx, FIN);
        end
    end

    // advance the next-odd key in the round after, off the registered x
    logic [127:0] kz_odd;
    assign kz_odd = (ODD_R && RNUM > 1) ? chain4(i_kz, sub_word(i_kx[127:96])) : i_kz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
        if (i_en) begin
            r_st <= ODD_R ? enc_round(i_st, kz_odd, 1'b0) : n_st;
            r_kx <= n_kx;
            r_kz <= ODD_R ? kz_odd : n_kz;
        end
    end

    assign o_tag = r_tag;
    assign o_st  = r_st;
    assign o_kx  = r_kx;
    assign o_kz  = r_kz;

endmodule

/* rtl/core/aes256_ctr_keystream.sv */
// Pipeline: 14 round cells, then the output register.
// Throughput: one 128-bit block per cycle through a 14-cell round chain while
// no output word is held; BLOCKS_PER_REQUEST blocks per input word (8 by
// default), set by the block counter.
// Reset: synchronous active low; clears key registers, counter and valid bits.
module aes256_ctr_keystream #(
    parameter int BLOCKS_PER_REQUEST = aesctr_pkg::BLOCKS_PER_REQUEST_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  aesctr_pkg::t_in_word   i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output aesctr_pkg::t_out_word  o_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [63:0]            i_cfg_data
);
    import aesctr_pkg::*;

    localparam int CW = (BLOCKS_PER_REQUEST > 1) ? $clog2(BLOCKS_PER_REQUEST) : 1;

    logic [255:0]  r_key;
    logic          r_busy;
    logic [CW-1:0] r_cnt;
    t_in_word      r_req;
    logic          en;

    t_tag         tg [NUM_ROUNDS+1];
    logic [127:0] st [NUM_ROUNDS+1];
    logic [127:0] kx [NUM_ROUNDS+1];
    logic [127:0] kz [NUM_ROUNDS+1];

    t_out_word r_out;
    logic      r_out_v;

    assign o_cfg_ready = i_rst_n;

    // write key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_key_reg'(i_cfg_index))
                KEY_WORD_0: r_key[63:0]    <= i_cfg_data;
                KEY_WORD_1: r_key[127:64]  <= i_cfg_data;
                KEY_WORD_2: r_key[191:128] <= i_cfg_data;
                KEY_WORD_3: r_key[255:192] <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // stall whole chain when output word is held
    assign en      = !r_out_v || i_ready;
    assign o_ready = en && !r_busy && i_rst_n;

    // issue one block per cycle per request while the chain is not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (en) begin
            if (!r_busy) begin
                if (i_valid && BLOCKS_PER_REQUEST > 1) begin
                    r_busy <= 1'b1;
                    r_cnt  <= CW'(1);
                end
            end else if (32'(r_cnt) == BLOCKS_PER_REQUEST - 1) begin
                r_busy <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
        if (o_ready && i_valid) r_req <= i_data;
    end

    // build counter block and whiten with first key half
    t_in_word      req;
    logic [CW-1:0] idx;
    logic [31:0]   ctr_a;
    assign req   = r_busy ? r_req : i_data;
    assign idx   = r_busy ? r_cnt : '0;
    assign ctr_a = req.counter_start[31:0] + 32'(idx);

    assign tg[0] = '{valid: en && (r_busy || i_valid),
                     last:  32'(idx) == BLOCKS_PER_REQUEST - 1,
                     index: 3'(idx)};
    assign st[0] = {req.nonce, req.counter_start[63:32], ctr_a} ^ r_key[127:0];
    assign kx[0] = r_key[127:0];
    assign kz[0] = r_key[255:128];

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_cell
        aesctr_round_cell #(.RNUM(g + 1)) u_cell (
            .i_clk, .i_rst_n, .i_en(en),
            .i_tag(tg[g]), .i_st(st[g]), .i_kx(kx[g]), .i_kz(kz[g]),
            .o_tag(tg[g+1]), .o_st(st[g+1]), .o_kx(kx[g+1]), .o_kz(kz[g+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= tg[NUM_ROUNDS].valid;
        end
        if (en) begin
            r_out <= '{last_block:  tg[NUM_ROUNDS].last,
                       stream_high: st[NUM_ROUNDS][127:64],
                       stream_low:  st[NUM_ROUNDS][63:0],
                       block_index: tg[NUM_ROUNDS].index};
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // a held output word must not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output word changed under stall");
    // no new request while blocks still issuing
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_ready)
        else $error("ready while issuing");
    // last flag only on final index
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.last_block |-> 32'(o_data.block_index) == ((BLOCKS_PER_REQUEST - 1) % 8))
        else $error("last flag on wrong block");

endmodule
